/* design/morm4_pkg.sv */
// Package: shared widths and constants for the four-sample outlier-reject mean.
`timescale 1ns / 1ps
`default_nettype none
package morm4_pkg;

  // fixed field widths
  localparam int ID_W     = 3;
  localparam int DIST_W   = 16;
  localparam int TOL_W    = 16;

  // ring geometry: four slots, 2-bit write position
  localparam int SLOTS    = 4;
  localparam int POS_W    = 2;

  // id widened for range checks against the sensor count
  localparam int ID_EXT_W = 8;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd100;

endpackage
`default_nettype wire

/* design/morm4_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module morm4_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/morm4_update.sv */
// Per-item row update: outlier test, slot write, position advance and mean.
`timescale 1ns / 1ps
`default_nettype none
module morm4_update #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic [morm4_pkg::SLOTS*SAMPLE_BITS-1:0] row,
  input  wire logic [morm4_pkg::POS_W-1:0]             pos,
  input  wire logic [SAMPLE_BITS-1:0]                  sample,
  input  wire logic [morm4_pkg::TOL_W-1:0]             tolerance,
  output logic      [morm4_pkg::SLOTS*SAMPLE_BITS-1:0] row_next,
  output logic      [morm4_pkg::POS_W-1:0]             pos_next,
  output logic      [SAMPLE_BITS-1:0]                  mean,
  output logic                                         rejected
);

  localparam int SUM_W = SAMPLE_BITS + 2;

  logic [morm4_pkg::POS_W-1:0] prev_pos;
  logic [SAMPLE_BITS-1:0]      prev;
  logic [SAMPLE_BITS-1:0]      diff;
  logic [SAMPLE_BITS-1:0]      keep;
  logic [SUM_W-1:0]            sum;

  // most recent stored sample sits one slot behind the write position
  assign prev_pos = pos - morm4_pkg::POS_W'(1);
  assign prev     = row[prev_pos*SAMPLE_BITS +: SAMPLE_BITS];

  // absolute jump against tolerance; a zero stored sample means no history
  always_comb begin
    diff     = (prev > sample) ? (prev - sample) : (sample - prev);
    rejected = (prev != '0) && (morm4_pkg::TOL_W'(diff) > tolerance);
    keep     = rejected ? prev : sample;
  end

  // write the kept value into its slot and sum the four slots
  always_comb begin
    row_next = row;
    sum      = '0;
    for (int k = 0; k < morm4_pkg::SLOTS; k++) begin
      if (pos == morm4_pkg::POS_W'(k)) begin
        row_next[k*SAMPLE_BITS +: SAMPLE_BITS] = keep;
      end
      sum = sum + SUM_W'(row_next[k*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign pos_next = pos + morm4_pkg::POS_W'(1);
  assign mean     = sum[SUM_W-1:2];

endmodule
`default_nettype wire

/* design/multichannel_outlier_reject_mean4.sv */
// Top level: per-sensor four-sample moving mean with outlier rejection.
//
// Input channel (in_valid/in_ready) carries sensor_id and distance. Output
// channel (out_valid/out_ready) returns out_sensor_id, mean_distance and
// sample_rejected, one result item per input item, in order.
// jump_tolerance_we writes jump_tolerance_wdata into the tolerance register
// on the same edge; write it only while the block is idle.
// A result passes through the update stage and the output register: the
// RAM read is issued on the accepting edge, the update then runs in the
// following cycle and lands in the output register once the output advances.
// Throughput: one item per cycle while the receiver does not stall. Each
// sensor's ring and write position sit in one RAM row, and a forwarding
// register supplies the row just written when the next item addresses the
// same sensor.
// Reset clears the tolerance to 100 and the per-row valid bits, so every
// ring reads as zero with position zero; no clearing pass is needed.
// A stalled receiver holds the output register; one more item can still be
// accepted into the update stage, then in_ready drops until out_ready.
// Sensor numbers at or above SENSORS change no state and return mean zero.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_outlier_reject_mean4 #(
  parameter int SENSORS     = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             jump_tolerance_we,
  input  wire logic [morm4_pkg::TOL_W-1:0]      jump_tolerance_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [morm4_pkg::ID_W-1:0]       sensor_id,
  input  wire logic [morm4_pkg::DIST_W-1:0]     distance,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [morm4_pkg::ID_W-1:0]       out_sensor_id,
  output logic      [morm4_pkg::DIST_W-1:0]     mean_distance,
  output logic                                  sample_rejected
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int ROW_W = morm4_pkg::SLOTS * SAMPLE_BITS;
  localparam int ENT_W = ROW_W + morm4_pkg::POS_W;
  localparam logic [morm4_pkg::ID_EXT_W-1:0] SENSOR_LIMIT =
    morm4_pkg::ID_EXT_W'(SENSORS);

  // tolerance register
  logic [morm4_pkg::TOL_W-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= morm4_pkg::TOL_RESET;
    end else if (jump_tolerance_we) begin
      tolerance <= jump_tolerance_wdata;
    end
  end

  // handshake and stage control
  logic in_fire;
  logic advance;
  logic s1_valid;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  // input decode
  logic [morm4_pkg::ID_EXT_W-1:0] id_ext;
  logic [IDX_W-1:0]               in_idx;

  assign id_ext = morm4_pkg::ID_EXT_W'(sensor_id);
  assign in_idx = id_ext[IDX_W-1:0];

  // update stage registers (payload, no reset)
  logic [morm4_pkg::ID_W-1:0] s1_id;
  logic [IDX_W-1:0]           s1_idx;
  logic                       s1_in_range;
  logic [SAMPLE_BITS-1:0]     s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_id       <= sensor_id;
      s1_idx      <= in_idx;
      s1_in_range <= id_ext < SENSOR_LIMIT;
      s1_sample   <= distance[SAMPLE_BITS-1:0];
    end
  end

  // row memory
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;

  morm4_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SENSORS),
    .ADDR_W(IDX_W)
  ) u_rows (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_idx),
    .wdata(wr_data),
    .re   (in_fire),
    .raddr(in_idx),
    .rdata(rd_data)
  );

  // per-row valid bits: an unwritten row reads as all zero
  logic [SENSORS-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[s1_idx] <= 1'b1;
    end
  end

  // forwarding of the last row written
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  logic [ENT_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx  <= s1_idx;
      fwd_data <= wr_data;
    end
  end

  // current row for the item in the update stage
  logic [ENT_W-1:0] cur_ent;

  always_comb begin
    if (fwd_valid && fwd_idx == s1_idx) begin
      cur_ent = fwd_data;
    end else if (s1_in_range && entry_valid[s1_idx]) begin
      cur_ent = rd_data;
    end else begin
      cur_ent = '0;
    end
  end

  // row update
  logic [ROW_W-1:0]            row_next;
  logic [morm4_pkg::POS_W-1:0] pos_next;
  logic [SAMPLE_BITS-1:0]      upd_mean;
  logic                        upd_rejected;

  morm4_update #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_update (
    .row      (cur_ent[ROW_W-1:0]),
    .pos      (cur_ent[ENT_W-1:ROW_W]),
    .sample   (s1_sample),
    .tolerance(tolerance),
    .row_next (row_next),
    .pos_next (pos_next),
    .mean     (upd_mean),
    .rejected (upd_rejected)
  );

  assign wr_en   = s1_valid && advance && s1_in_range;
  assign wr_data = {pos_next, row_next};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_sensor_id   <= s1_id;
      mean_distance   <= s1_in_range ? morm4_pkg::DIST_W'(upd_mean) : '0;
      sample_rejected <= s1_in_range && upd_rejected;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && morm4_pkg::ID_EXT_W'(out_sensor_id) >= SENSOR_LIMIT)
      |-> (mean_distance == '0 && !sample_rejected))
    else $error("out-of-range sensor produced a nonzero result");

  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (entry_valid[fwd_idx] && fwd_valid))
    else $error("row write did not mark its entry valid");

endmodule
`default_nettype wire
